@@ hdl/assert_macros.svh @@
// Assertion macros shared by the depth back-projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

@@ hdl/dpp_pkg.sv @@
// Constants shared by the depth back-projection modules.
`timescale 1ns / 1ps
package dpp_pkg;
    // Configuration register indexes
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_DEPTH_ENC = 3'd4;

    // Depth encodings
    localparam logic ENC_MM    = 1'b0;
    localparam logic ENC_FLOAT = 1'b1;

    // Reset values
    localparam logic [31:0] FOCAL_RESET = 32'd32768000;

    // Saturation limits in Q16.16
    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;
    localparam logic [30:0] Z_MAX     = 31'h7FFF_FFFF;

    // Millimetre to Q16.16 metres: floor(((raw << 16) + 500) / 1000)
    localparam logic [31:0] MM_ROUND = 32'd500;
    localparam logic [29:0] MM_RECIP = 30'd549755814; // ceil(2^36 / 125)
    localparam int          MM_SHIFT = 36;

    // binary32 fields
    localparam logic [7:0] FLT_EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] FLT_EXP_Q16     = 8'd134;
    localparam logic [7:0] FLT_MAX_LSHIFT  = 8'd8;
    localparam logic [7:0] FLT_MAX_RSHIFT  = 8'd24;

    // Projection lane: three arithmetic stages, one per quotient bit, one final
    localparam int DIV_STEPS   = 32;
    localparam int PROJ_LAT    = DIV_STEPS + 4;
    localparam int QUEUE_DEPTH = 4;
endpackage

@@ hdl/dpp_queue.sv @@
// Small synchronous queue between the pipeline parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpp_queue
    import dpp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    // Storage is written at the tail.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > (AW+1)'(DEPTH))
    `ASSERT_AT(a_count_up, clk, rst_n, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
    `ASSERT_AT(a_count_down, clk, rst_n, (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
endmodule

@@ hdl/dpp_front.sv @@
// Front part: classifies the raw depth word and converts it to Q16.16 metres.
`timescale 1ns / 1ps
module dpp_front
    import dpp_pkg::*;
(
    input  logic        depth_encoding,
    input  logic [31:0] depth_word,
    output logic [30:0] z,
    output logic        z_valid
);
    logic [7:0]  ex;
    logic [7:0]  ex_eff;
    logic [23:0] man;
    logic        flt_ok;
    logic [7:0]  shamt;
    logic [31:0] lsh;
    logic [47:0] rsh;
    logic [24:0] rnd;
    logic [30:0] z_flt;
    logic [15:0] raw;
    logic [31:0] mm_num;
    logic [58:0] mm_prod;

    // Float metres: exponent and mantissa, subnormals use exponent one.
    always_comb
    begin
        ex     = depth_word[30:23];
        ex_eff = (ex == 8'd0) ? 8'd1 : ex;
        man    = {(ex != 8'd0), depth_word[22:0]};
        flt_ok = (ex != FLT_EXP_SPECIAL) && !depth_word[31]
                 && !((ex == 8'd0) && (depth_word[22:0] == 23'd0));
        shamt  = '0;
        lsh    = '0;
        rsh    = '0;
        rnd    = '0;
        if (ex_eff >= FLT_EXP_Q16)
        begin
            shamt = ex_eff - FLT_EXP_Q16;
            lsh   = {8'd0, man} << shamt[2:0];
            if (shamt >= FLT_MAX_LSHIFT || lsh[31])
            begin
                z_flt = Z_MAX;
            end
            else
            begin
                z_flt = lsh[30:0];
            end
        end
        else
        begin
            shamt = FLT_EXP_Q16 - ex_eff;
            if (shamt > FLT_MAX_RSHIFT)
            begin
                z_flt = '0;
            end
            else
            begin
                // Round half up on the first bit shifted out.
                rsh   = {man, 24'd0} >> shamt[4:0];
                rnd   = {1'b0, rsh[47:24]} + {24'd0, rsh[23]};
                z_flt = 31'(rnd);
            end
        end
    end

    // Millimetres: divide by 1000 through a reciprocal of 125 after a shift by three.
    always_comb
    begin
        raw     = depth_word[15:0];
        mm_num  = {raw, 16'd0} + MM_ROUND;
        mm_prod = 59'(mm_num[31:3]) * 59'(MM_RECIP);
    end

    // Select the encoding; an invalid depth carries zero.
    always_comb
    begin
        if (depth_encoding == ENC_FLOAT)
        begin
            z_valid = flt_ok;
            z       = flt_ok ? z_flt : '0;
        end
        else
        begin
            z_valid = (raw != 16'd0);
            z       = 31'(mm_prod[58:MM_SHIFT]);
        end
    end
endmodule

@@ hdl/dpp_proj.sv @@
// One projection lane: (coord - centre) * z / focal, rounded and saturated.
`timescale 1ns / 1ps
module dpp_proj
    import dpp_pkg::*;
#(
    parameter int CB = 12
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [CB-1:0] coord,
    input  logic [31:0]   center,
    input  logic [31:0]   focal,
    input  logic [30:0]   z,
    output logic [31:0]   result
);
    logic [31:0] a;
    logic [31:0] mag_reg;
    logic        neg0_reg;
    logic [30:0] z0_reg;
    logic [62:0] prod_reg;
    logic        neg1_reg;
    logic [63:0] num;
    logic [31:0] rem_reg [0:DIV_STEPS];
    logic [31:0] quo_reg [0:DIV_STEPS];
    logic        neg_reg [0:DIV_STEPS];
    logic        zero_reg [0:DIV_STEPS];
    logic        ovf_reg [0:DIV_STEPS];
    logic [31:0] q;
    logic [31:0] res_reg;

    assign a   = 32'(coord) << 16;
    assign num = {1'b0, prod_reg} + {33'd0, focal[31:1]};

    // Offset from the principal point as sign and magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= (a < center);
            mag_reg  <= (a < center) ? (center - a) : (a - center);
            z0_reg   <= z;
        end
    end

    // Product of offset and depth.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {31'd0, mag_reg} * {32'd0, z0_reg};
            neg1_reg <= neg0_reg;
        end
    end

    // Add half the focal length; a high word not below the divisor overflows.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num[63:32];
            quo_reg[0]  <= num[31:0];
            neg_reg[0]  <= neg1_reg;
            zero_reg[0] <= (prod_reg == '0);
            ovf_reg[0]  <= (num[63:32] >= focal);
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [32:0] trial;
        logic        ge;

        assign trial = {rem_reg[i], quo_reg[i][31]};
        assign ge    = (trial >= {1'b0, focal});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? 32'(trial - {1'b0, focal}) : trial[31:0];
                quo_reg[i+1]  <= {quo_reg[i][30:0], ge};
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
            end
        end
    end

    // Saturate toward the sign of the offset and apply the sign.
    always_comb
    begin
        q = quo_reg[DIV_STEPS];
        if (ovf_reg[DIV_STEPS])
        begin
            q = neg_reg[DIV_STEPS] ? Q_NEG_MAX : Q_POS_MAX;
        end
        else if (neg_reg[DIV_STEPS] && q > Q_NEG_MAX)
        begin
            q = Q_NEG_MAX;
        end
        else if (!neg_reg[DIV_STEPS] && q > Q_POS_MAX)
        begin
            q = Q_POS_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[DIV_STEPS])
            begin
                res_reg <= '0;
            end
            else
            begin
                res_reg <= neg_reg[DIV_STEPS] ? (32'd0 - q) : q;
            end
        end
    end

    assign result = res_reg;
endmodule

@@ hdl/dpp_back.sv @@
// Back part: projection pipeline for both axes with a stall that holds every stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpp_back
    import dpp_pkg::*;
#(
    parameter int CB = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   focal_x,
    input  logic [31:0]   focal_y,
    input  logic [31:0]   center_x,
    input  logic [31:0]   center_y,
    input  logic          in_empty,
    input  logic [CB-1:0] in_col,
    input  logic [CB-1:0] in_row,
    input  logic [30:0]   in_z,
    input  logic          in_valid,
    output logic          in_pop,
    input  logic          out_full,
    output logic          out_push,
    output logic [31:0]   out_x,
    output logic [31:0]   out_y,
    output logic [30:0]   out_z,
    output logic          out_valid
);
    logic                en;
    logic [PROJ_LAT-1:0] vld_reg;
    logic [30:0]         z_reg [0:PROJ_LAT-1];
    logic                pv_reg [0:PROJ_LAT-1];
    logic [31:0]         x_res;
    logic [31:0]         y_res;

    // The whole pipeline moves only while the result queue has room.
    assign en       = !out_full;
    assign in_pop   = en && !in_empty;
    assign out_push = en && vld_reg[PROJ_LAT-1];

    dpp_proj #(.CB(CB)) u_proj_x
    (
        .clk    (clk),
        .en     (en),
        .coord  (in_col),
        .center (center_x),
        .focal  (focal_x),
        .z      (in_z),
        .result (x_res)
    );

    dpp_proj #(.CB(CB)) u_proj_y
    (
        .clk    (clk),
        .en     (en),
        .coord  (in_row),
        .center (center_y),
        .focal  (focal_y),
        .z      (in_z),
        .result (y_res)
    );

    // Occupancy of each stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PROJ_LAT-2:0], !in_empty};
        end
    end

    // Depth and validity travel alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]  <= in_z;
            pv_reg[0] <= in_valid;
            for (int i = 1; i < PROJ_LAT; i++)
            begin
                z_reg[i]  <= z_reg[i-1];
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    // An invalid depth gives zero coordinates.
    assign out_valid = pv_reg[PROJ_LAT-1];
    assign out_x     = out_valid ? x_res : '0;
    assign out_y     = out_valid ? y_res : '0;
    assign out_z     = out_valid ? z_reg[PROJ_LAT-1] : '0;

    `ASSERT_AT(a_stall_holds, clk, rst_n, !en |=> $stable(vld_reg))
    `ASSERT_AT(a_pop_enters, clk, rst_n, in_pop |=> vld_reg[0])
    `ASSERT_NEVER(a_invalid_zero, clk, rst_n, out_push && !out_valid && (out_x != '0 || out_y != '0 || out_z != '0))
endmodule

@@ hdl/depth_pixel_to_point.sv @@
// Top level of the pinhole depth back-projection block.
//
//  Channel   Handshake                  Payload
//  input     push / full                pixel_col, pixel_row, depth_word
//  result    pop / empty                point_x, point_y, point_z, point_valid
//  config    cfg_write (no wait)        cfg_index, cfg_data
//
// One pixel is accepted every clock while full is low; the sustained rate is one
// transaction per cycle while the result queue has room. A pixel passes the middle
// queue, the 32-stage restoring divider in each projection lane and the result queue.
// Reset is asynchronous; it clears the queues and the stage valid bits and sets the config registers to reset values.
// A stalled result queue freezes the back pipeline; the middle queue then fills and
// raises full.
`timescale 1ns / 1ps
module depth_pixel_to_point
    import dpp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] pixel_col,
    input  logic [COORD_BITS-1:0] pixel_row,
    input  logic [31:0]           depth_word,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [31:0]    point_x,
    output logic signed [31:0]    point_y,
    output logic [30:0]           point_z,
    output logic                  point_valid
);
    localparam int MID_W = 2 * COORD_BITS + 32;
    localparam int OUT_W = 96;

    logic [31:0]           focal_x_reg;
    logic [31:0]           focal_y_reg;
    logic [31:0]           center_x_reg;
    logic [31:0]           center_y_reg;
    logic                  enc_reg;
    logic [30:0]           front_z;
    logic                  front_valid;
    logic                  mid_empty;
    logic                  mid_pop;
    logic [MID_W-1:0]      mid_dout;
    logic [COORD_BITS-1:0] mid_col;
    logic [COORD_BITS-1:0] mid_row;
    logic [30:0]           mid_z;
    logic                  mid_valid;
    logic                  out_full;
    logic                  out_push;
    logic [31:0]           back_x;
    logic [31:0]           back_y;
    logic [30:0]           back_z;
    logic                  back_valid;
    logic [OUT_W-1:0]      out_dout;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= FOCAL_RESET;
            focal_y_reg  <= FOCAL_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            enc_reg      <= ENC_MM;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL_X:   focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:   focal_y_reg  <= cfg_data;
                REG_CENTER_X:  center_x_reg <= cfg_data;
                REG_CENTER_Y:  center_y_reg <= cfg_data;
                REG_DEPTH_ENC: enc_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Front: depth conversion on the accepted transaction.
    dpp_front u_front
    (
        .depth_encoding (enc_reg),
        .depth_word     (depth_word),
        .z              (front_z),
        .z_valid        (front_valid)
    );

    // Queue between front and back.
    dpp_queue #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({pixel_col, pixel_row, front_z, front_valid}),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign {mid_col, mid_row, mid_z, mid_valid} = mid_dout;

    // Back: projection of both axes.
    dpp_back #(.CB(COORD_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .focal_x   (focal_x_reg),
        .focal_y   (focal_y_reg),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .in_empty  (mid_empty),
        .in_col    (mid_col),
        .in_row    (mid_row),
        .in_z      (mid_z),
        .in_valid  (mid_valid),
        .in_pop    (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_x     (back_x),
        .out_y     (back_y),
        .out_z     (back_z),
        .out_valid (back_valid)
    );

    // Result queue towards the consumer.
    dpp_queue #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   ({back_x, back_y, back_z, back_valid}),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign point_x     = signed'(out_dout[95:64]);
    assign point_y     = signed'(out_dout[63:32]);
    assign point_z     = out_dout[31:1];
    assign point_valid = out_dout[0];
endmodule
